// ===== hw/rtl/rotate_point_about_origin_macros.svh =====
// Assertion macros for the point rotation block
`ifndef ROTATE_POINT_ABOUT_ORIGIN_MACROS_SVH
`define ROTATE_POINT_ABOUT_ORIGIN_MACROS_SVH

// Checked while out of reset
`define RPO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked during reset as well
`define RPO_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== hw/rtl/rpo_pkg.sv =====
package rpo_pkg;

    localparam int ANGLE_W      = 18;
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam int RED_W        = 17;
    localparam int RES_W        = 15;
    localparam int Z_SHIFT      = 8;
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 25;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // atan(2^-i) in 1/65536 degree
    localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
        25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
        25'sd115,     25'sd57,      25'sd29
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic  valid;
        quad_t quad;
    } stage_ctl_t;

endpackage

// ===== hw/rtl/rotate_point_about_origin.sv =====
// Rotates a point about a pivot by an angle in 1/256-degree units. Fully pipelined: one item
// is accepted every cycle while the pipeline is not halted. Each item passes through angle
// reduction and offset, 18 CORDIC iterations, then rounding, multiplying, summing, truncation,
// pivot add-back and saturation. The whole pipeline advances as one; it halts only while a
// result sits in the output register and m_ready is low, so s_ready follows m_ready in that
// case and is high whenever the output register is empty or being read.
module rotate_point_about_origin
    import rpo_pkg::*;
#(
    parameter int COORD_WIDTH        = 16,
    parameter int TRIG_FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_origin_x,
    input  logic signed [COORD_WIDTH-1:0] s_origin_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic signed [ANGLE_W-1:0]     s_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_rotated_x,
    output logic signed [COORD_WIDTH-1:0] m_rotated_y,
    output logic                          m_saturated
);

    localparam int CW     = COORD_WIDTH;
    localparam int SIDE_W = 4 * CW + 2;

    logic                          pipe_en;
    logic signed [CW-1:0]          prep_ox;
    logic signed [CW-1:0]          prep_oy;
    logic signed [CW:0]            prep_dx;
    logic signed [CW:0]            prep_dy;

    stage_ctl_t                    cd_ctl  [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0]    cd_x    [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0]    cd_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]         cd_z    [CORDIC_STEPS+1];
    logic [SIDE_W-1:0]             cd_side [CORDIC_STEPS+1];

    logic signed [CW-1:0]          end_ox;
    logic signed [CW-1:0]          end_oy;
    logic signed [CW:0]            end_dx;
    logic signed [CW:0]            end_dy;

    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    rpo_angle_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_valid(s_valid),
        .origin_x(s_origin_x),
        .origin_y(s_origin_y),
        .point_x (s_point_x),
        .point_y (s_point_y),
        .angle   (s_angle),
        .ctl_out (cd_ctl[0]),
        .z_out   (cd_z[0]),
        .ox_out  (prep_ox),
        .oy_out  (prep_oy),
        .dx_out  (prep_dx),
        .dy_out  (prep_dy)
    );

    assign cd_x[0]    = CORDIC_GAIN;
    assign cd_y[0]    = '0;
    assign cd_side[0] = {prep_ox, prep_oy, prep_dx, prep_dy};

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        rpo_cordic_stage #(
            .STEP  (i),
            .SIDE_W(SIDE_W)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .ctl_in  (cd_ctl[i]),
            .x_in    (cd_x[i]),
            .y_in    (cd_y[i]),
            .z_in    (cd_z[i]),
            .side_in (cd_side[i]),
            .ctl_out (cd_ctl[i+1]),
            .x_out   (cd_x[i+1]),
            .y_out   (cd_y[i+1]),
            .z_out   (cd_z[i+1]),
            .side_out(cd_side[i+1])
        );
    end

    assign {end_ox, end_oy, end_dx, end_dy} = cd_side[CORDIC_STEPS];

    rpo_rotate_out #(
        .COORD_WIDTH       (COORD_WIDTH),
        .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .ctl_in   (cd_ctl[CORDIC_STEPS]),
        .x_in     (cd_x[CORDIC_STEPS]),
        .y_in     (cd_y[CORDIC_STEPS]),
        .ox_in    (end_ox),
        .oy_in    (end_oy),
        .dx_in    (end_dx),
        .dy_in    (end_dy),
        .out_valid(m_valid),
        .rotated_x(m_rotated_x),
        .rotated_y(m_rotated_y),
        .saturated(m_saturated)
    );

endmodule

// ===== hw/rtl/rpo_angle_prep.sv =====
module rpo_angle_prep
    import rpo_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [ANGLE_W-1:0]     angle,
    output stage_ctl_t                    ctl_out,
    output logic signed [Z_W-1:0]         z_out,
    output logic signed [COORD_WIDTH-1:0] ox_out,
    output logic signed [COORD_WIDTH-1:0] oy_out,
    output logic signed [COORD_WIDTH:0]   dx_out,
    output logic signed [COORD_WIDTH:0]   dy_out
);

    localparam logic signed [ANGLE_W:0] FULL_S     = (ANGLE_W+1)'(FULL_TURN);
    localparam logic signed [ANGLE_W:0] NEG_FULL_S = -FULL_S;
    localparam logic signed [ANGLE_W:0] TWO_FULL_S = (ANGLE_W+1)'(2 * FULL_TURN);
    localparam logic [RED_W-1:0]        Q1_A       = RED_W'(QUARTER_TURN);
    localparam logic [RED_W-1:0]        Q2_A       = RED_W'(2 * QUARTER_TURN);
    localparam logic [RED_W-1:0]        Q3_A       = RED_W'(3 * QUARTER_TURN);

    logic                          valid1_reg;
    logic [RED_W-1:0]              red_reg;
    logic [RED_W-1:0]              red_next;
    logic signed [COORD_WIDTH-1:0] ox1_reg;
    logic signed [COORD_WIDTH-1:0] oy1_reg;
    logic signed [COORD_WIDTH:0]   dx1_reg;
    logic signed [COORD_WIDTH:0]   dy1_reg;
    logic signed [COORD_WIDTH:0]   dx1_next;
    logic signed [COORD_WIDTH:0]   dy1_next;
    logic signed [ANGLE_W:0]       ang_ext;
    logic signed [ANGLE_W:0]       wrapped;

    stage_ctl_t                    ctl_reg;
    stage_ctl_t                    ctl_next;
    logic signed [Z_W-1:0]         z_reg;
    logic signed [Z_W-1:0]         z_next;
    logic [RED_W-1:0]              res;
    logic signed [COORD_WIDTH-1:0] ox2_reg;
    logic signed [COORD_WIDTH-1:0] oy2_reg;
    logic signed [COORD_WIDTH:0]   dx2_reg;
    logic signed [COORD_WIDTH:0]   dy2_reg;

    assign ang_ext = (ANGLE_W+1)'(angle);

    // reduce the angle into one full turn
    always_comb begin
        if (ang_ext >= FULL_S) begin
            wrapped = ang_ext - FULL_S;
        end else if (!ang_ext[ANGLE_W]) begin
            wrapped = ang_ext;
        end else if (ang_ext >= NEG_FULL_S) begin
            wrapped = ang_ext + FULL_S;
        end else begin
            wrapped = ang_ext + TWO_FULL_S;
        end
        red_next = wrapped[RED_W-1:0];
        dx1_next = {point_x[COORD_WIDTH-1], point_x} - {origin_x[COORD_WIDTH-1], origin_x};
        dy1_next = {point_y[COORD_WIDTH-1], point_y} - {origin_y[COORD_WIDTH-1], origin_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg <= red_next;
            ox1_reg <= origin_x;
            oy1_reg <= origin_y;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
        end
    end

    // split into quadrant and residue
    always_comb begin
        ctl_next.valid = valid1_reg;
        if (red_reg >= Q3_A) begin
            ctl_next.quad = QUAD_3;
            res           = red_reg - Q3_A;
        end else if (red_reg >= Q2_A) begin
            ctl_next.quad = QUAD_2;
            res           = red_reg - Q2_A;
        end else if (red_reg >= Q1_A) begin
            ctl_next.quad = QUAD_1;
            res           = red_reg - Q1_A;
        end else begin
            ctl_next.quad = QUAD_0;
            res           = red_reg;
        end
        z_next = Z_W'({res[RES_W-1:0], {Z_SHIFT{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg        <= z_next;
            ox2_reg      <= ox1_reg;
            oy2_reg      <= oy1_reg;
            dx2_reg      <= dx1_reg;
            dy2_reg      <= dy1_reg;
        end
    end

    assign ctl_out = ctl_reg;
    assign z_out   = z_reg;
    assign ox_out  = ox2_reg;
    assign oy_out  = oy2_reg;
    assign dx_out  = dx2_reg;
    assign dy_out  = dy2_reg;

endmodule

// ===== hw/rtl/rpo_cordic_stage.sv =====
module rpo_cordic_stage
    import rpo_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 66
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  stage_ctl_t                 ctl_in,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [Z_W-1:0]      z_in,
    input  logic [SIDE_W-1:0]          side_in,
    output stage_ctl_t                 ctl_out,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [Z_W-1:0]      z_out,
    output logic [SIDE_W-1:0]          side_out
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = ATAN_TABLE[STEP];

    stage_ctl_t                 ctl_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [SIDE_W-1:0]          side_reg;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [Z_W-1:0]      z_next;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;

    always_comb begin
        if (!z_in[Z_W-1]) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_STEP;
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            z_reg        <= z_next;
            side_reg     <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

// ===== hw/rtl/rpo_rotate_out.sv =====
module rpo_rotate_out
    import rpo_pkg::*;
#(
    parameter int COORD_WIDTH        = 16,
    parameter int TRIG_FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  stage_ctl_t                    ctl_in,
    input  logic signed [CORDIC_W-1:0]    x_in,
    input  logic signed [CORDIC_W-1:0]    y_in,
    input  logic signed [COORD_WIDTH-1:0] ox_in,
    input  logic signed [COORD_WIDTH-1:0] oy_in,
    input  logic signed [COORD_WIDTH:0]   dx_in,
    input  logic signed [COORD_WIDTH:0]   dy_in,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic                          saturated
);

    localparam int F  = TRIG_FRACTION_BITS;
    localparam int DW = COORD_WIDTH + 1;
    localparam int TW = F + 2;
    localparam int RW = CORDIC_W + 1;
    localparam int SH = 30 - F;
    localparam int PW = DW + TW;
    localparam int SW = PW + 1;
    localparam int QW = SW - F;
    localparam int OW = QW + 1;

    localparam logic signed [RW-1:0] HALF      = RW'(64'sd1 <<< (SH - 1));
    localparam logic signed [RW-1:0] ONE_W     = RW'(64'sd1 <<< F);
    localparam logic signed [RW-1:0] NEG_ONE_W = -ONE_W;
    localparam logic signed [SW-1:0] BIAS      = SW'((64'sd1 <<< F) - 64'sd1);
    localparam logic signed [OW-1:0] MAX_V     = OW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [OW-1:0] MIN_V     = -MAX_V - OW'(1);

    function automatic logic signed [TW-1:0] to_trig(input logic signed [CORDIC_W-1:0] q);
        logic signed [RW-1:0] qe;
        logic signed [RW-1:0] r;
        qe = RW'(q);
        r  = (qe + HALF) >>> SH;
        if (r > ONE_W) begin
            to_trig = ONE_W[TW-1:0];
        end else if (r < NEG_ONE_W) begin
            to_trig = NEG_ONE_W[TW-1:0];
        end else begin
            to_trig = r[TW-1:0];
        end
    endfunction

    logic                          v1_reg;
    logic signed [TW-1:0]          c_reg;
    logic signed [TW-1:0]          s_reg;
    logic signed [TW-1:0]          c_next;
    logic signed [TW-1:0]          s_next;
    logic signed [TW-1:0]          cq;
    logic signed [TW-1:0]          sq;
    logic signed [DW-1:0]          dx1_reg;
    logic signed [DW-1:0]          dy1_reg;
    logic signed [COORD_WIDTH-1:0] ox1_reg;
    logic signed [COORD_WIDTH-1:0] oy1_reg;

    logic                          v2_reg;
    logic signed [PW-1:0]          pxc_reg;
    logic signed [PW-1:0]          pys_reg;
    logic signed [PW-1:0]          pxs_reg;
    logic signed [PW-1:0]          pyc_reg;
    logic signed [COORD_WIDTH-1:0] ox2_reg;
    logic signed [COORD_WIDTH-1:0] oy2_reg;

    logic                          v3_reg;
    logic signed [SW-1:0]          sx_reg;
    logic signed [SW-1:0]          sy_reg;
    logic signed [COORD_WIDTH-1:0] ox3_reg;
    logic signed [COORD_WIDTH-1:0] oy3_reg;

    logic                          v4_reg;
    logic signed [QW-1:0]          qx_reg;
    logic signed [QW-1:0]          qy_reg;
    logic signed [QW-1:0]          qx_next;
    logic signed [QW-1:0]          qy_next;
    logic signed [SW-1:0]          bx;
    logic signed [SW-1:0]          by;
    logic signed [COORD_WIDTH-1:0] ox4_reg;
    logic signed [COORD_WIDTH-1:0] oy4_reg;

    logic                          v5_reg;
    logic signed [OW-1:0]          ux_reg;
    logic signed [OW-1:0]          uy_reg;

    logic                          v6_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg;
    logic signed [COORD_WIDTH-1:0] ry_reg;
    logic                          sat_reg;
    logic signed [COORD_WIDTH-1:0] rx_next;
    logic signed [COORD_WIDTH-1:0] ry_next;
    logic                          sat_next;

    // round to the trig format and map to the quadrant
    always_comb begin
        cq = to_trig(x_in);
        sq = to_trig(y_in);
        case (ctl_in.quad)
            QUAD_0: begin
                c_next = cq;
                s_next = sq;
            end
            QUAD_1: begin
                c_next = -sq;
                s_next = cq;
            end
            QUAD_2: begin
                c_next = -cq;
                s_next = -sq;
            end
            default: begin
                c_next = sq;
                s_next = -cq;
            end
        endcase
    end

    // truncate toward zero on the divide by the trig scale
    always_comb begin
        bx      = sx_reg + (sx_reg[SW-1] ? BIAS : '0);
        by      = sy_reg + (sy_reg[SW-1] ? BIAS : '0);
        qx_next = QW'(bx >>> F);
        qy_next = QW'(by >>> F);
    end

    always_comb begin
        sat_next = 1'b0;
        if (ux_reg > MAX_V) begin
            rx_next  = MAX_V[COORD_WIDTH-1:0];
            sat_next = 1'b1;
        end else if (ux_reg < MIN_V) begin
            rx_next  = MIN_V[COORD_WIDTH-1:0];
            sat_next = 1'b1;
        end else begin
            rx_next = ux_reg[COORD_WIDTH-1:0];
        end
        if (uy_reg > MAX_V) begin
            ry_next  = MAX_V[COORD_WIDTH-1:0];
            sat_next = 1'b1;
        end else if (uy_reg < MIN_V) begin
            ry_next  = MIN_V[COORD_WIDTH-1:0];
            sat_next = 1'b1;
        end else begin
            ry_next = uy_reg[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ctl_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            dx1_reg <= dx_in;
            dy1_reg <= dy_in;
            ox1_reg <= ox_in;
            oy1_reg <= oy_in;

            pxc_reg <= PW'(dx1_reg) * PW'(c_reg);
            pys_reg <= PW'(dy1_reg) * PW'(s_reg);
            pxs_reg <= PW'(dx1_reg) * PW'(s_reg);
            pyc_reg <= PW'(dy1_reg) * PW'(c_reg);
            ox2_reg <= ox1_reg;
            oy2_reg <= oy1_reg;

            sx_reg  <= SW'(pxc_reg) - SW'(pys_reg);
            sy_reg  <= SW'(pxs_reg) + SW'(pyc_reg);
            ox3_reg <= ox2_reg;
            oy3_reg <= oy2_reg;

            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            ox4_reg <= ox3_reg;
            oy4_reg <= oy3_reg;

            ux_reg  <= OW'(qx_reg) + OW'(ox4_reg);
            uy_reg  <= OW'(qy_reg) + OW'(oy4_reg);

            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v6_reg;
    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;
    assign saturated = sat_reg;

endmodule

// ===== hw/rtl/rpo_checker.sv =====
`include "rotate_point_about_origin_macros.svh"

module rpo_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_WIDTH-1:0] m_rotated_x,
    input logic signed [COORD_WIDTH-1:0] m_rotated_y,
    input logic                          m_saturated
);

    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                   at_limit;
    logic                   m_stall;
    logic [2*COORD_WIDTH:0] m_payload;

    assign at_limit  = (m_rotated_x == SAT_MAX) || (m_rotated_x == SAT_MIN) ||
                       (m_rotated_y == SAT_MAX) || (m_rotated_y == SAT_MIN);
    assign m_stall   = m_valid && !m_ready;
    assign m_payload = {m_rotated_x, m_rotated_y, m_saturated};

    `RPO_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    `RPO_ASSERT(a_room_ready, (!m_valid || m_ready) |-> s_ready, "input held off with room")

    `RPO_ASSERT(a_sat_clipped, m_valid && m_saturated |-> at_limit, "flag without clipped value")

    `RPO_ASSERT(a_out_hold, m_stall |=> m_valid && $stable(m_payload), "stalled result changed")

endmodule

bind rotate_point_about_origin rpo_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_rpo_checker (.*);

// ===== test/tb_rotate_point_about_origin.sv =====
module tb_rotate_point_about_origin;
    import rpo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 16;
    localparam int TRIG_F  = 16;
    localparam longint TURN_UNITS    = 92160;
    localparam longint QUARTER_UNITS = 23040;
    localparam int     ATAN_STEPS    = 18;
    localparam longint GAIN_Q30      = 652032874;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [ANGLE_W-1:0] ang;
    } point_item_t;

    class rotation_scoreboard;
        typedef struct packed {
            logic signed [COORD_W-1:0] x;
            logic signed [COORD_W-1:0] y;
            logic                      sat;
        } rotation_t;

        rotation_t rotations_due[$];
        int        errors;
        int        n_accepted;
        local longint atan_q16 [ATAN_STEPS] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
        };

        function longint to_fixed_trig(longint q30);
            longint one;
            longint v;
            one = longint'(1) << TRIG_F;
            v = (q30 + (longint'(1) << (29 - TRIG_F))) >>> (30 - TRIG_F);
            if (v > one) v = one;
            if (v < -one) v = -one;
            return v;
        endfunction

        function longint shift_toward_zero(longint v);
            if (v >= 0) return v >>> TRIG_F;
            return -((-v) >>> TRIG_F);
        endfunction

        function logic signed [COORD_W-1:0] clip_coord(longint v, inout logic flag);
            longint hi;
            longint lo;
            hi = (longint'(1) << (COORD_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                flag = 1'b1;
                v = hi;
            end else if (v < lo) begin
                flag = 1'b1;
                v = lo;
            end
            return COORD_W'(v);
        endfunction

        function rotation_t rotate_about_pivot(point_item_t it);
            longint    a, x, y, z, xs, ys, cq, sq, c, s, dx, dy, rx, ry;
            quad_t     quad;
            rotation_t r;
            a = longint'(it.ang) % TURN_UNITS;
            if (a < 0) a += TURN_UNITS;
            quad = quad_t'(a / QUARTER_UNITS);
            z = (a % QUARTER_UNITS) * 256;
            x = GAIN_Q30;
            y = 0;
            for (int i = 0; i < ATAN_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= atan_q16[i];
                end else begin
                    x += ys;
                    y -= xs;
                    z += atan_q16[i];
                end
            end
            cq = to_fixed_trig(x);
            sq = to_fixed_trig(y);
            case (quad)
                QUAD_0: begin c = cq;  s = sq;  end
                QUAD_1: begin c = -sq; s = cq;  end
                QUAD_2: begin c = -cq; s = -sq; end
                default: begin c = sq; s = -cq; end
            endcase
            dx = longint'(it.px) - longint'(it.ox);
            dy = longint'(it.py) - longint'(it.oy);
            rx = shift_toward_zero(dx * c - dy * s) + longint'(it.ox);
            ry = shift_toward_zero(dx * s + dy * c) + longint'(it.oy);
            r.sat = 1'b0;
            r.x = clip_coord(rx, r.sat);
            r.y = clip_coord(ry, r.sat);
            return r;
        endfunction

        function void note_input(point_item_t it);
            n_accepted++;
            rotations_due.push_back(rotate_about_pivot(it));
        endfunction

        task report(string what, logic signed [31:0] got, logic signed [31:0] want);
            errors++;
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(logic signed [COORD_W-1:0] rx, logic signed [COORD_W-1:0] ry,
                          logic sat);
            rotation_t want;
            if (rotations_due.size() == 0) begin
                report("unexpected item", rx, 0);
                return;
            end
            want = rotations_due.pop_front();
            if (rx !== want.x) report("rotated_x", rx, want.x);
            if (ry !== want.y) report("rotated_y", ry, want.y);
            if (sat !== want.sat) report("saturated", sat, want.sat);
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_origin_x;
    logic signed [COORD_W-1:0] s_origin_y;
    logic signed [COORD_W-1:0] s_point_x;
    logic signed [COORD_W-1:0] s_point_y;
    logic signed [ANGLE_W-1:0] s_angle;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_rotated_x;
    logic signed [COORD_W-1:0] m_rotated_y;
    logic                      m_saturated;

    rotation_scoreboard sb = new;
    point_item_t        items_to_send[$];

    rotate_point_about_origin #(
        .COORD_WIDTH       (COORD_W),
        .TRIG_FRACTION_BITS(TRIG_F)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_origin_x (s_origin_x),
        .s_origin_y (s_origin_y),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_angle    (s_angle),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rotated_x(m_rotated_x),
        .m_rotated_y(m_rotated_y),
        .m_saturated(m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input('{s_origin_x, s_origin_y, s_point_x, s_point_y, s_angle});
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_rotated_x, m_rotated_y, m_saturated);
    end

    function automatic point_item_t random_item();
        point_item_t it;
        int          kind, ox, oy;
        kind = $urandom_range(0, 9);
        it.ox = COORD_W'($urandom);
        it.oy = COORD_W'($urandom);
        it.px = COORD_W'($urandom);
        it.py = COORD_W'($urandom);
        it.ang = ANGLE_W'($urandom);
        if (kind >= 4 && kind <= 8) begin
            ox = int'($urandom_range(0, 40000)) - 20000;
            oy = int'($urandom_range(0, 40000)) - 20000;
            it.ox = COORD_W'(ox);
            it.oy = COORD_W'(oy);
            it.px = COORD_W'(ox + int'($urandom_range(0, 4000)) - 2000);
            it.py = COORD_W'(oy + int'($urandom_range(0, 4000)) - 2000);
        end
        if (kind >= 7 && kind <= 8)
            it.ang = ANGLE_W'((int'($urandom_range(0, 8)) - 4) * 23040
                              + int'($urandom_range(0, 6)) - 3);
        if (kind == 9) begin
            it.px = it.ox;
            it.py = it.oy;
        end
        return it;
    endfunction

    task automatic add_item(int ox, int oy, int px, int py, int ang);
        items_to_send.push_back('{COORD_W'(ox), COORD_W'(oy), COORD_W'(px), COORD_W'(py),
                                  ANGLE_W'(ang)});
    endtask

    task automatic drive_item(point_item_t it);
        s_valid    <= 1'b1;
        s_origin_x <= it.ox;
        s_origin_y <= it.oy;
        s_point_x  <= it.px;
        s_point_y  <= it.py;
        s_angle    <= it.ang;
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver: random stall patterns, plus one long hold-off once traffic is flowing
    initial begin
        int   mode, left, cyc;
        logic rdy;
        bit   held_off;
        m_ready <= 1'b0;
        left = 0;
        cyc = 0;
        held_off = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held_off && sb.n_accepted >= 300) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                held_off = 1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (cyc % 4 == 0);
                    default: rdy = ($urandom_range(0, 9) != 0);
                endcase
                m_ready <= rdy;
                @(posedge aclk);
                cyc++;
            end
        end
    end

    initial begin
        int burst, gap;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_origin_x <= '0;
        s_origin_y <= '0;
        s_point_x  <= '0;
        s_point_y  <= '0;
        s_angle    <= '0;

        add_item(0, 0, 0, 0, 0);
        add_item(100, -200, 100, -200, 12345);
        add_item(0, 0, 1000, 0, 23040);
        add_item(0, 0, 1000, 500, 46080);
        add_item(0, 0, 1000, 500, 69120);
        add_item(10, 20, 1000, 500, 92160);
        add_item(10, 20, 1000, 500, -92160);
        add_item(-7, 3, 1000, 500, -23040);
        add_item(0, 0, 12345, -2345, 131071);
        add_item(0, 0, 12345, -2345, -131072);
        add_item(-32768, -32768, 32767, 32767, 0);
        add_item(-32768, -32768, 32767, 32767, 11520);
        add_item(32767, 32767, -32768, -32768, 46080);
        add_item(0, 0, 32767, -32768, 23040);
        add_item(0, 0, -32768, -32768, 46080);
        add_item(500, 500, 600, 400, 1);
        add_item(500, 500, 600, 400, 23039);
        add_item(500, 500, 600, 400, 23041);
        add_item(-32768, 32767, -32768, 32767, 92159);
        add_item(32767, -32768, 32767, -32768, -1);
        repeat (1000) items_to_send.push_back(random_item());

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        burst = 0;
        foreach (items_to_send[i]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 60);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            drive_item(items_to_send[i]);
            burst--;
        end
        s_valid <= 1'b0;

        while (sb.rotations_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
